### rtl/grbfs_pkg.sv
// shared types and constants for the graph reachability block
`default_nettype none

package grbfs_pkg;

  // vertex fields on the ports are four bits wide
  localparam int unsigned VTX_W = 4;
  localparam int unsigned VTX_LIMIT = 1 << VTX_W;

  // opcodes of an input word
  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_QUERY    = 1'b1;

  // status of one expansion step
  typedef struct packed {
    logic empty;  // no vertex left to expand
    logic hit;    // the target turned up among the new neighbors
  } step_status_t;

endpackage

`default_nettype wire

### rtl/grbfs_expand.sv
// one expansion step of the walk: pick a pending vertex and merge its row
`default_nettype none

module grbfs_expand #(
  parameter int unsigned NumVtx = 16,
  parameter int unsigned IdxW   = 4
) (
  input  wire logic [NumVtx-1:0] pending_i,
  input  wire logic [NumVtx-1:0] visited_i,
  input  wire logic [NumVtx-1:0] row_i,
  input  wire logic [IdxW-1:0]   target_i,
  output logic [IdxW-1:0]        cur_o,
  output logic [NumVtx-1:0]      pending_o,
  output logic [NumVtx-1:0]      visited_o,
  output grbfs_pkg::step_status_t status_o
);

  logic [NumVtx-1:0] lowbit;
  logic [NumVtx-1:0] fresh;

  // isolate the lowest pending vertex
  assign lowbit = pending_i & (~pending_i + NumVtx'(1));

  // encode its index, each bit contributes independently
  always_comb begin
    cur_o = '0;
    for (int unsigned i = 0; i < NumVtx; i++) begin
      if (lowbit[i]) begin
        cur_o = cur_o | IdxW'(i);
      end
    end
  end

  // neighbors not seen before
  assign fresh = row_i & ~visited_i;

  // next sets
  assign pending_o = (pending_i & ~lowbit) | fresh;
  assign visited_o = visited_i | fresh;

  // step status
  assign status_o.empty = (pending_i == '0);
  assign status_o.hit   = fresh[target_i];

endmodule

`default_nettype wire

### rtl/graph_reachability_bfs.sv
// reachability over a stored directed graph, one vertex expanded per cycle
// edge insert: no result, the block stays ready
// query: a registered result strobe follows the accept or the end of the walk;
// the walk expands one row of the adjacency matrix a cycle
// busy stays high during the walk; the receiver takes each result as shown
// reset clears all edges, the walk state and the result strobe at once
`default_nettype none

module graph_reachability_bfs #(
  parameter int unsigned NUM_VERTICES = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        opcode_i,
  input  wire logic [grbfs_pkg::VTX_W-1:0] from_vertex_i,
  input  wire logic [grbfs_pkg::VTX_W-1:0] to_vertex_i,
  output logic                             result_valid_o,
  output logic                             reachable_o
);

  // only vertices that the port fields can name are stored
  localparam int unsigned NumVtx = (NUM_VERTICES < grbfs_pkg::VTX_LIMIT) ?
                                   NUM_VERTICES : grbfs_pkg::VTX_LIMIT;
  localparam int unsigned IdxW   = $clog2(NumVtx);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic                state_q, state_d;
  logic [NumVtx-1:0]   adj_q [NumVtx];
  logic [NumVtx-1:0]   visited_q, visited_d;
  logic [NumVtx-1:0]   pending_q, pending_d;
  logic [IdxW-1:0]     target_q, target_d;
  logic                valid_q, valid_d;
  logic                reach_q, reach_d;

  logic                accept;
  logic                from_ok, to_ok;
  logic [IdxW-1:0]     from_idx, to_idx;
  logic [IdxW-1:0]     cur_idx;
  logic [NumVtx-1:0]   step_pending, step_visited;
  grbfs_pkg::step_status_t step_status;

  assign accept   = start && !busy;
  assign from_ok  = ({1'b0, from_vertex_i} < (grbfs_pkg::VTX_W + 1)'(NumVtx));
  assign to_ok    = ({1'b0, to_vertex_i} < (grbfs_pkg::VTX_W + 1)'(NumVtx));
  assign from_idx = from_vertex_i[IdxW-1:0];
  assign to_idx   = to_vertex_i[IdxW-1:0];

  // shared expansion unit
  grbfs_expand #(
    .NumVtx (NumVtx),
    .IdxW   (IdxW)
  ) u_expand (
    .pending_i (pending_q),
    .visited_i (visited_q),
    .row_i     (adj_q[cur_idx]),
    .target_i  (target_q),
    .cur_o     (cur_idx),
    .pending_o (step_pending),
    .visited_o (step_visited),
    .status_o  (step_status)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    visited_d = visited_q;
    pending_d = pending_q;
    target_d  = target_q;
    valid_d   = 1'b0;
    reach_d   = reach_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && opcode_i == grbfs_pkg::OP_QUERY) begin
          if (!from_ok || !to_ok) begin
            valid_d = 1'b1;
            reach_d = 1'b0;
          end else if (from_idx == to_idx) begin
            valid_d = 1'b1;
            reach_d = 1'b1;
          end else begin
            state_d   = ST_WALK;
            visited_d = NumVtx'(1) << from_idx;
            pending_d = NumVtx'(1) << from_idx;
            target_d  = to_idx;
          end
        end
      end
      ST_WALK: begin
        if (step_status.empty) begin
          state_d = ST_IDLE;
          valid_d = 1'b1;
          reach_d = 1'b0;
        end else if (step_status.hit) begin
          state_d = ST_IDLE;
          valid_d = 1'b1;
          reach_d = 1'b1;
        end else begin
          visited_d = step_visited;
          pending_d = step_pending;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      visited_q <= '0;
      pending_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      visited_q <= visited_d;
      pending_q <= pending_d;
      valid_q   <= valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    target_q <= target_d;
    reach_q  <= reach_d;
  end

  // adjacency matrix, one bit set per in-range edge insert
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned r = 0; r < NumVtx; r++) begin
        adj_q[r] <= '0;
      end
    end else if (accept && opcode_i == grbfs_pkg::OP_ADD_EDGE && from_ok && to_ok) begin
      adj_q[from_idx][to_idx] <= 1'b1;
    end
  end

  assign busy           = (state_q == ST_WALK);
  assign result_valid_o = valid_q;
  assign reachable_o    = reach_q;

  // an edge insert never produces a result word
  a_edge_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && opcode_i == grbfs_pkg::OP_ADD_EDGE |=> !result_valid_o)
    else $error("result word after edge insert");

  // the target is never marked visited while the walk goes on
  a_target_unvisited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> !visited_q[target_q])
    else $error("target visited during walk");

  // every pending vertex is also visited
  a_pending_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q & ~visited_q) == '0)
    else $error("pending vertex not visited");

  // start equal to target answers reached on the next cycle
  a_self_reached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && opcode_i == grbfs_pkg::OP_QUERY && from_ok && to_ok &&
    from_vertex_i == to_vertex_i |=> result_valid_o && reachable_o)
    else $error("self query not reached");

  // the result strobe only shows once the walk is over
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result word while busy");

endmodule

`default_nettype wire

### sim/grbfs_reach_checker.sv
// checker for the graph reachability block: tracks the graph, predicts answers, compares
module grbfs_reach_checker #(
  parameter int unsigned NUM_VERTICES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic                        opcode_i,
  input  logic [grbfs_pkg::VTX_W-1:0] from_vertex_i,
  input  logic [grbfs_pkg::VTX_W-1:0] to_vertex_i,
  input  logic                        result_valid_i,
  input  logic                        reachable_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o,
  output int unsigned                 hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // one query waiting for its answer
  typedef struct packed {
    logic [grbfs_pkg::VTX_W-1:0] src;
    logic [grbfs_pkg::VTX_W-1:0] dst;
    logic                        reach;
  } reach_exp_t;

  logic [NUM_VERTICES-1:0] edge_rows [NUM_VERTICES];
  reach_exp_t              answer_q [$];

  // breadth-first walk over the tracked graph
  function automatic logic graph_reaches(input logic [grbfs_pkg::VTX_W-1:0] src,
                                         input logic [grbfs_pkg::VTX_W-1:0] dst);
    logic [NUM_VERTICES-1:0] seen;
    int unsigned             frontier [$];
    int unsigned             cur;
    if (src >= NUM_VERTICES || dst >= NUM_VERTICES) return 1'b0;
    if (src == dst) return 1'b1;
    seen = '0;
    seen[src] = 1'b1;
    frontier.push_back(src);
    while (frontier.size() > 0) begin
      cur = frontier.pop_front();
      for (int w = 0; w < NUM_VERTICES; w++) begin
        if (edge_rows[cur][w] && !seen[w]) begin
          if (w == dst) return 1'b1;
          seen[w] = 1'b1;
          frontier.push_back(w);
        end
      end
    end
    return 1'b0;
  endfunction

  // count a failure, describe only the first few
  task automatic report_fault(input string msg);
    fail_count_o++;
    if (fail_count_o <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // answers are checked before a word of the same edge is taken in
  always @(posedge clk_i or negedge rst_ni) begin : track
    reach_exp_t head;
    reach_exp_t fresh;
    if (!rst_ni) begin
      for (int r = 0; r < NUM_VERTICES; r++) edge_rows[r] = '0;
      answer_q.delete();
      fail_count_o = 0;
      hits_o = 0;
    end else begin
      // result strobe
      if (result_valid_i !== 1'b0) begin
        if (answer_q.size() == 0) begin
          report_fault($sformatf("answer %b with no query outstanding", reachable_i));
        end else begin
          head = answer_q.pop_front();
          if (reachable_i !== head.reach)
            report_fault($sformatf("query %0d->%0d reachable expected %b got %b",
                                   head.src, head.dst, head.reach, reachable_i));
        end
        if (reachable_i === 1'b1) hits_o++;
      end
      // accepted word
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        if (opcode_i == grbfs_pkg::OP_ADD_EDGE) begin
          if (from_vertex_i < NUM_VERTICES && to_vertex_i < NUM_VERTICES)
            edge_rows[from_vertex_i][to_vertex_i] = 1'b1;
        end else begin
          fresh.src = from_vertex_i;
          fresh.dst = to_vertex_i;
          fresh.reach = graph_reaches(from_vertex_i, to_vertex_i);
          answer_q.push_back(fresh);
        end
      end
    end
    pending_o = answer_q.size();
  end

endmodule

### sim/tb_graph_reachability_bfs.sv
// testbench top for the graph reachability block: stimulus, reset, clock and verdict
module tb_graph_reachability_bfs;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NV           = 16;
  localparam int unsigned RANDOM_WORDS = 450;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 24;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic                        opcode_i;
  logic [grbfs_pkg::VTX_W-1:0] from_vertex_i;
  logic [grbfs_pkg::VTX_W-1:0] to_vertex_i;
  logic                        result_valid_o;
  logic                        reachable_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned hits;
  int unsigned cycle_count;
  int unsigned edges_sent;
  int unsigned queries_sent;
  bit          gaps_on;
  logic [grbfs_pkg::VTX_W-1:0] order [NV];

  graph_reachability_bfs #(.NUM_VERTICES(NV)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .from_vertex_i (from_vertex_i),
    .to_vertex_i   (to_vertex_i),
    .result_valid_o(result_valid_o),
    .reachable_o   (reachable_o)
  );

  grbfs_reach_checker #(.NUM_VERTICES(NV)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .opcode_i      (opcode_i),
    .from_vertex_i (from_vertex_i),
    .to_vertex_i   (to_vertex_i),
    .result_valid_i(result_valid_o),
    .reachable_i   (reachable_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .hits_o        (hits)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_graph_reachability_bfs failed");
      $finish;
    end
  end

  // drive one word at a falling edge and hold it until the block takes it
  task automatic send_word(input logic op, input logic [grbfs_pkg::VTX_W-1:0] src,
                           input logic [grbfs_pkg::VTX_W-1:0] dst);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    repeat (gap) begin
      start = 1'b0;
      opcode_i = 1'($urandom);
      from_vertex_i = grbfs_pkg::VTX_W'($urandom);
      to_vertex_i = grbfs_pkg::VTX_W'($urandom);
      @(negedge clk_i);
    end
    start = 1'b1;
    opcode_i = op;
    from_vertex_i = src;
    to_vertex_i = dst;
    do @(posedge clk_i); while (busy !== 1'b0);
    @(negedge clk_i);
    if (op == grbfs_pkg::OP_ADD_EDGE) edges_sent++;
    else queries_sent++;
  endtask

  // random word: mostly queries; edges are mostly short forward hops along a shuffled
  // vertex order, so paths grow long; back edges and arbitrary edges come late
  task automatic send_random_word(input int unsigned idx);
    int unsigned pick;
    int unsigned i;
    int unsigned j;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      i = $urandom_range(0, NV - 2);
      pick = $urandom_range(0, 9);
      if (pick < 7) j = (i + 1 + pick % 2 > NV - 1) ? NV - 1 : i + 1 + pick % 2;
      else if (pick < 9 || idx < 360) j = $urandom_range(i + 1, NV - 1);
      else j = $urandom_range(0, i);
      if (idx >= 400 && $urandom_range(0, 3) == 0)
        send_word(grbfs_pkg::OP_ADD_EDGE, grbfs_pkg::VTX_W'($urandom),
                  grbfs_pkg::VTX_W'($urandom));
      else
        send_word(grbfs_pkg::OP_ADD_EDGE, order[i], order[j]);
    end else begin
      send_word(grbfs_pkg::OP_QUERY, order[$urandom_range(0, NV - 1)],
                order[$urandom_range(0, NV - 1)]);
    end
  endtask

  // stimulus and verdict
  initial begin
    int unsigned k;
    logic [grbfs_pkg::VTX_W-1:0] tmp;
    rst_ni = 1'b0;
    start = 1'b0;
    opcode_i = grbfs_pkg::OP_ADD_EDGE;
    from_vertex_i = '0;
    to_vertex_i = '0;
    cycle_count = 0;
    edges_sent = 0;
    queries_sent = 0;
    gaps_on = 1'b1;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty graph, self loop, duplicates, cycles, two-hop finds
    send_word(grbfs_pkg::OP_QUERY, 4'd0, 4'd0);
    send_word(grbfs_pkg::OP_QUERY, 4'd15, 4'd15);
    send_word(grbfs_pkg::OP_QUERY, 4'd0, 4'd15);
    send_word(grbfs_pkg::OP_QUERY, 4'd15, 4'd0);
    send_word(grbfs_pkg::OP_ADD_EDGE, 4'd3, 4'd3);
    send_word(grbfs_pkg::OP_QUERY, 4'd3, 4'd4);
    send_word(grbfs_pkg::OP_ADD_EDGE, 4'd3, 4'd3);
    send_word(grbfs_pkg::OP_QUERY, 4'd3, 4'd3);
    send_word(grbfs_pkg::OP_ADD_EDGE, 4'd0, 4'd1);
    send_word(grbfs_pkg::OP_QUERY, 4'd0, 4'd1);
    send_word(grbfs_pkg::OP_QUERY, 4'd1, 4'd0);
    send_word(grbfs_pkg::OP_ADD_EDGE, 4'd1, 4'd0);
    send_word(grbfs_pkg::OP_QUERY, 4'd0, 4'd2);
    send_word(grbfs_pkg::OP_ADD_EDGE, 4'd5, 4'd15);
    send_word(grbfs_pkg::OP_ADD_EDGE, 4'd15, 4'd14);
    send_word(grbfs_pkg::OP_QUERY, 4'd5, 4'd14);
    send_word(grbfs_pkg::OP_QUERY, 4'd14, 4'd5);
    send_word(grbfs_pkg::OP_ADD_EDGE, 4'd0, 4'd5);
    send_word(grbfs_pkg::OP_QUERY, 4'd1, 4'd14);
    send_word(grbfs_pkg::OP_QUERY, 4'd14, 4'd1);
    send_word(grbfs_pkg::OP_ADD_EDGE, 4'd0, 4'd1);

    // shuffle the vertex order for the random part
    for (int v = 0; v < NV; v++) order[v] = grbfs_pkg::VTX_W'(v);
    for (int v = NV - 1; v > 0; v--) begin
      k = $urandom_range(0, v);
      tmp = order[v];
      order[v] = order[k];
      order[k] = tmp;
    end

    // random part, with stretches of back-to-back words
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      send_random_word(n);
    end
    start = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d edge inserts and %0d reachability queries with random gaps",
             edges_sent, queries_sent);
    $display("%0d answers reached the target, %0d did not", hits, queries_sent - hits);
    if (fail_count == 0) begin
      $display("tb_graph_reachability_bfs passed");
    end else begin
      $display("tb_graph_reachability_bfs failed");
    end
    $finish;
  end

endmodule
